// ===== rtl/fault_event_ring_log_dedup_unit_macros.svh =====
// Assertion macros shared by the fault event log RTL.
// Depends on nothing; the including module provides clock and reset.
`ifndef FAULT_EVENT_RING_LOG_DEDUP_UNIT_MACROS_SVH
`define FAULT_EVENT_RING_LOG_DEDUP_UNIT_MACROS_SVH

// Same-cycle implication.
`define FERLD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ferld assertion failed");

// Next-cycle implication.
`define FERLD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ferld assertion failed");

`endif

// ===== rtl/ferld_pkg.sv =====
// Types and constants for the fault event ring log.
// Used by ferld_ctrl, ferld_datapath and the top level.
package ferld_pkg;

   localparam int unsigned TIME_W  = 32;
   localparam int unsigned CODE_W  = 4;
   localparam int unsigned SEV_W   = 2;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned WORD_W  = 16;
   localparam int unsigned IDX_W   = 5;
   localparam int unsigned COUNT_W = 6;
   localparam int unsigned CNT32_W = 32;

   localparam logic [TIME_W-1:0] REPEAT_WINDOW_RESET = 32'd60000;
   localparam logic [SEV_W-1:0]  COMMIT_SEV_RESET    = 2'd2;

   localparam logic CSR_REPEAT_WINDOW = 1'b0;
   localparam logic CSR_COMMIT_SEV    = 1'b1;

   typedef enum logic [1:0] {
      FUNC_RECORD = 2'd0,
      FUNC_READ   = 2'd1,
      FUNC_FLUSH  = 2'd2,
      FUNC_CLEAR  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      STAT_STORED     = 3'd0,
      STAT_SUPPRESSED = 3'd1,
      STAT_READ_OK    = 3'd2,
      STAT_OUT_RANGE  = 3'd3,
      STAT_FLUSHED    = 3'd4,
      STAT_CLEARED    = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      ENTRY_NONE = 2'd0,
      ENTRY_REQ  = 2'd1,
      ENTRY_MEM  = 2'd2
   } entry_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_LOAD = 3'b100
   } ctrl_state_type;

   typedef struct packed {
      logic [WORD_W-1:0] current;
      logic [WORD_W-1:0] flow;
      logic [BYTE_W-1:0] level;
      logic [BYTE_W-1:0] state;
      logic [SEV_W-1:0]  severity;
      logic [CODE_W-1:0] code;
      logic [TIME_W-1:0] time_ms;
   } entry_type;

   typedef struct packed {
      func_type         func;
      entry_type        entry;
      logic [IDX_W-1:0] read_index;
   } req_item_type;

   typedef struct packed {
      status_type         status;
      logic               commit;
      entry_type          entry;
      logic [COUNT_W-1:0] entry_count;
      logic [CNT32_W-1:0] sequence_count;
      logic [CNT32_W-1:0] suppressed_count;
   } rsp_item_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic rsp_free;
   } dp_status_type;

endpackage

// ===== rtl/ferld_ctrl.sv =====
// Request sequencer for the fault event ring log: capture, ring access, result load.
// Depends on ferld_pkg and the assertion macro header.
`include "fault_event_ring_log_dedup_unit_macros.svh"

module ferld_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  ferld_pkg::dp_status_type dp_status,
   output ferld_pkg::ctrl_cmd_type  cmd
);

   ferld_pkg::ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.exec    = 1'b0;
      cmd.load    = 1'b0;
      case (state_ff)
         ferld_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ferld_pkg::ST_EXEC;
            end
         end
         ferld_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ferld_pkg::ST_LOAD;
         end
         ferld_pkg::ST_LOAD: begin
            if (dp_status.rsp_free) begin
               cmd.load = 1'b1;
               state_in = ferld_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ferld_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_tready = (state_ff == ferld_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ferld_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `FERLD_ASSERT_NEXT(a_capture_to_exec, cmd.capture, state_ff == ferld_pkg::ST_EXEC)
   `FERLD_ASSERT_NEXT(a_exec_to_load, cmd.exec, state_ff == ferld_pkg::ST_LOAD)
   `FERLD_ASSERT_NEXT(a_load_to_idle, cmd.load, state_ff == ferld_pkg::ST_IDLE)

endmodule

// ===== rtl/ferld_datapath.sv =====
// Datapath of the fault event ring log: ring memory, counters, config, result register.
// Depends on ferld_pkg and the assertion macro header.
`include "fault_event_ring_log_dedup_unit_macros.svh"

module ferld_datapath #(
   parameter int unsigned LOG_DEPTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  ferld_pkg::ctrl_cmd_type          cmd,
   output ferld_pkg::dp_status_type         dp_status,
   input  ferld_pkg::req_item_type          req_item,
   input  logic                             csr_valid,
   input  logic                             csr_index,
   input  logic [ferld_pkg::TIME_W-1:0]     csr_data,
   output ferld_pkg::rsp_item_type          rsp_item,
   output logic                             rsp_valid,
   input  logic                             rsp_tready
);

   localparam int unsigned IW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
   localparam int unsigned CW = $clog2(LOG_DEPTH + 1);
   localparam int unsigned SW = ((IW > ferld_pkg::IDX_W) ? IW : ferld_pkg::IDX_W) + 1;
   localparam int unsigned XW = (CW > ferld_pkg::COUNT_W) ? CW : ferld_pkg::COUNT_W;
   localparam int unsigned KW = (CW > ferld_pkg::IDX_W) ? CW : ferld_pkg::IDX_W;

   ferld_pkg::entry_type ring_mem [LOG_DEPTH];

   ferld_pkg::req_item_type req_ff;
   ferld_pkg::entry_type    rd_data_ff;
   ferld_pkg::rsp_item_type rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic [IW-1:0]                  wp_ff, wp_in;
   logic [CW-1:0]                  count_ff, count_in;
   logic [ferld_pkg::CNT32_W-1:0]  seq_ff, seq_in;
   logic [ferld_pkg::CNT32_W-1:0]  supp_ff, supp_in;
   logic                           pending_ff, pending_in;
   logic [ferld_pkg::CODE_W-1:0]   prev_code_ff, prev_code_in;
   logic [ferld_pkg::TIME_W-1:0]   prev_time_ff, prev_time_in;
   logic [ferld_pkg::TIME_W-1:0]   window_ff, window_in;
   logic [ferld_pkg::SEV_W-1:0]    commit_sev_ff, commit_sev_in;

   ferld_pkg::status_type    status_ff, status_in;
   logic                     commit_ff, commit_in;
   ferld_pkg::entry_sel_type sel_ff, sel_in;

   logic                         is_record, is_read;
   logic                         suppress, store, read_ok;
   logic [ferld_pkg::TIME_W-1:0] delta;
   logic [IW-1:0]                wp_next, newest_slot, read_slot, rd_addr;
   logic [IW-1:0]                start_slot;
   logic [SW-1:0]                slot_sum;
   logic [XW-1:0]                count_x;

   always_comb begin
      is_record = (req_ff.func == ferld_pkg::FUNC_RECORD);
      is_read   = (req_ff.func == ferld_pkg::FUNC_READ);

      delta    = req_ff.entry.time_ms - prev_time_ff;
      suppress = is_record && (count_ff != '0) && (req_ff.entry.code == prev_code_ff)
                 && (delta < window_ff);
      store    = is_record && !suppress;

      wp_next     = (wp_ff == IW'(LOG_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
      newest_slot = (wp_ff == '0) ? IW'(LOG_DEPTH - 1) : wp_ff - 1'b1;
      start_slot  = (count_ff == CW'(LOG_DEPTH)) ? wp_ff : '0;
      slot_sum    = SW'(start_slot) + SW'(req_ff.read_index);
      if (slot_sum >= SW'(LOG_DEPTH)) begin
         slot_sum = slot_sum - SW'(LOG_DEPTH);
      end
      read_slot = slot_sum[IW-1:0];
      read_ok   = is_read && (KW'(req_ff.read_index) < KW'(count_ff));
      rd_addr   = is_read ? read_slot : newest_slot;
   end

   always_comb begin
      wp_in         = wp_ff;
      count_in      = count_ff;
      seq_in        = seq_ff;
      supp_in       = supp_ff;
      pending_in    = pending_ff;
      prev_code_in  = prev_code_ff;
      prev_time_in  = prev_time_ff;
      status_in     = status_ff;
      commit_in     = commit_ff;
      sel_in        = sel_ff;
      window_in     = window_ff;
      commit_sev_in = commit_sev_ff;

      if (csr_valid) begin
         case (csr_index)
            ferld_pkg::CSR_REPEAT_WINDOW: window_in = csr_data;
            ferld_pkg::CSR_COMMIT_SEV:    commit_sev_in = csr_data[ferld_pkg::SEV_W-1:0];
            default: begin
            end
         endcase
      end

      if (cmd.exec) begin
         commit_in = 1'b0;
         sel_in    = ferld_pkg::ENTRY_NONE;
         case (req_ff.func)
            ferld_pkg::FUNC_RECORD: begin
               if (suppress) begin
                  supp_in   = supp_ff + 1'b1;
                  status_in = ferld_pkg::STAT_SUPPRESSED;
               end else begin
                  prev_code_in = req_ff.entry.code;
                  prev_time_in = req_ff.entry.time_ms;
                  wp_in        = wp_next;
                  if (count_ff < CW'(LOG_DEPTH)) begin
                     count_in = count_ff + 1'b1;
                  end
                  seq_in    = seq_ff + 1'b1;
                  status_in = ferld_pkg::STAT_STORED;
                  if (req_ff.entry.severity >= commit_sev_ff) begin
                     commit_in = 1'b1;
                     sel_in    = ferld_pkg::ENTRY_REQ;
                  end else begin
                     pending_in = 1'b1;
                  end
               end
            end
            ferld_pkg::FUNC_READ: begin
               if (read_ok) begin
                  status_in = ferld_pkg::STAT_READ_OK;
                  sel_in    = ferld_pkg::ENTRY_MEM;
               end else begin
                  status_in = ferld_pkg::STAT_OUT_RANGE;
               end
            end
            ferld_pkg::FUNC_FLUSH: begin
               status_in = ferld_pkg::STAT_FLUSHED;
               if (pending_ff) begin
                  pending_in = 1'b0;
                  if (count_ff != '0) begin
                     commit_in = 1'b1;
                     sel_in    = ferld_pkg::ENTRY_MEM;
                  end
               end
            end
            default: begin
               wp_in        = '0;
               count_in     = '0;
               seq_in       = '0;
               supp_in      = '0;
               pending_in   = 1'b0;
               prev_code_in = '0;
               prev_time_in = '0;
               status_in    = ferld_pkg::STAT_CLEARED;
            end
         endcase
      end
   end

   always_comb begin
      count_x                 = XW'(count_ff);
      rsp_in                  = rsp_ff;
      rsp_valid_in            = rsp_valid_ff && !rsp_tready;
      if (cmd.load) begin
         rsp_in.status           = status_ff;
         rsp_in.commit           = commit_ff;
         rsp_in.entry_count      = count_x[ferld_pkg::COUNT_W-1:0];
         rsp_in.sequence_count   = seq_ff;
         rsp_in.suppressed_count = supp_ff;
         case (sel_ff)
            ferld_pkg::ENTRY_REQ: rsp_in.entry = req_ff.entry;
            ferld_pkg::ENTRY_MEM: rsp_in.entry = rd_data_ff;
            default:              rsp_in.entry = '0;
         endcase
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && store) begin
         ring_mem[wp_ff] <= req_ff.entry;
      end
      if (cmd.exec) begin
         rd_data_ff <= ring_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_item;
      end
      rsp_ff    <= rsp_in;
      status_ff <= status_in;
      commit_ff <= commit_in;
      sel_ff    <= sel_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff         <= '0;
         count_ff      <= '0;
         seq_ff        <= '0;
         supp_ff       <= '0;
         pending_ff    <= 1'b0;
         prev_code_ff  <= '0;
         prev_time_ff  <= '0;
         window_ff     <= ferld_pkg::REPEAT_WINDOW_RESET;
         commit_sev_ff <= ferld_pkg::COMMIT_SEV_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         wp_ff         <= wp_in;
         count_ff      <= count_in;
         seq_ff        <= seq_in;
         supp_ff       <= supp_in;
         pending_ff    <= pending_in;
         prev_code_ff  <= prev_code_in;
         prev_time_ff  <= prev_time_in;
         window_ff     <= window_in;
         commit_sev_ff <= commit_sev_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_item           = rsp_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign dp_status.rsp_free = !rsp_valid_ff || rsp_tready;

   `FERLD_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CW'(LOG_DEPTH))
   `FERLD_ASSERT_NOW(a_load_when_free, cmd.load, !rsp_valid_ff || rsp_tready)
   `FERLD_ASSERT_NEXT(a_suppress_counts, cmd.exec && suppress, supp_ff == $past(supp_ff) + 1'b1)

endmodule

// ===== rtl/fault_event_ring_log_dedup_unit.sv =====
// Top level of the fault event ring log with repeat suppression.
// Depends on ferld_pkg, ferld_ctrl and ferld_datapath.
//
//  channel  direction  handshake              payload
//  req_     in         req_tvalid/req_tready  tuser func, tdata event fields
//  rsp_     out        rsp_tvalid/rsp_tready  tuser status+commit, tdata entry+counts
//  csr_     in         csr_valid/csr_ready    csr_index, csr_data
//
// A request passes through capture, one ring memory access and result load.
// The next request is taken the cycle after the result loads; a result that is
// not yet taken waits in the output register and stalls only the load step.
// Synchronous reset clears counters, presets config; ring needs no clearing pass.
// csr writes are always ready.

module fault_event_ring_log_dedup_unit #(
   parameter int unsigned LOG_DEPTH = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // time[31:0] code[35:32] severity[37:36] state[45:38] level[53:46]
   // flow[69:54] current[85:70] read_index[90:86]
   input  logic [95:0]   req_tdata,
   // func[1:0]
   input  logic [1:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // time[31:0] code[35:32] severity[37:36] state[45:38] level[53:46] flow[69:54]
   // current[85:70] entry_count[91:86] sequence_count[123:92] suppressed[155:124]
   output logic [159:0]  rsp_tdata,
   // status[2:0] commit[3]
   output logic [3:0]    rsp_tuser,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic          csr_index,
   input  logic [31:0]   csr_data
);

   ferld_pkg::ctrl_cmd_type  cmd;
   ferld_pkg::dp_status_type dp_status;
   ferld_pkg::req_item_type  req_item;
   ferld_pkg::rsp_item_type  rsp_item;

   assign req_item.func             = ferld_pkg::func_type'(req_tuser);
   assign req_item.entry.time_ms    = req_tdata[31:0];
   assign req_item.entry.code       = req_tdata[35:32];
   assign req_item.entry.severity   = req_tdata[37:36];
   assign req_item.entry.state      = req_tdata[45:38];
   assign req_item.entry.level      = req_tdata[53:46];
   assign req_item.entry.flow       = req_tdata[69:54];
   assign req_item.entry.current    = req_tdata[85:70];
   assign req_item.read_index       = req_tdata[90:86];

   assign rsp_tdata = {4'd0, rsp_item.suppressed_count, rsp_item.sequence_count,
                       rsp_item.entry_count, rsp_item.entry.current, rsp_item.entry.flow,
                       rsp_item.entry.level, rsp_item.entry.state, rsp_item.entry.severity,
                       rsp_item.entry.code, rsp_item.entry.time_ms};
   assign rsp_tuser = {rsp_item.commit, rsp_item.status};
   assign csr_ready = 1'b1;

   ferld_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .dp_status  (dp_status),
      .cmd        (cmd)
   );

   ferld_datapath #(
      .LOG_DEPTH (LOG_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .dp_status  (dp_status),
      .req_item   (req_item),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_item   (rsp_item),
      .rsp_valid  (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

endmodule
